// ----- rtl/lrc_pkg.sv -----
`timescale 1ns / 1ps
package lrc_pkg;

    // defaults for the top-level parameters
    localparam int DEPTH_DEF     = 16;
    localparam int KEY_WIDTH_DEF = 32;

    // fixed field widths of the ports
    localparam int KEY_W    = 32;
    localparam int RANK_W   = 4;
    localparam int CNT_OUT_W = 5;
    localparam int CAP_W    = 5;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // word index of the capacity register (paddr[2])
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic {
        OP_ACCESS = 1'b0,
        OP_CLEAR  = 1'b1
    } t_op;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic load;   // an access transfer is taken this cycle
        logic hit;    // the key matched some valid cell
    } t_cell_ctl;

endpackage

// ----- rtl/lrc_cell.sv -----
`timescale 1ns / 1ps
module lrc_cell #(
    parameter int IDX   = 0,
    parameter int SW    = 32,
    parameter int RK_W  = 4,
    parameter int CNT_W = 5
) (
    input  logic                 i_clk,
    input  lrc_pkg::t_cell_ctl   i_ctl,
    input  logic [CNT_W-1:0]     i_count,
    input  logic [SW-1:0]        i_key,
    input  logic [SW-1:0]        i_prev_key,
    input  logic                 i_match_after,
    input  logic [RK_W-1:0]      i_rank_acc,
    input  logic [SW-1:0]        i_last_acc,
    output logic [SW-1:0]        o_key,
    output logic                 o_match_from,
    output logic [RK_W-1:0]      o_rank_acc,
    output logic [SW-1:0]        o_last_acc
);
    import lrc_pkg::*;

    logic [SW-1:0] r_key;
    logic          valid;
    logic          is_last;
    logic          match;
    logic          shift_en;

    assign valid    = CNT_W'(IDX) < i_count;
    assign is_last  = CNT_W'(IDX + 1) == i_count;
    assign match    = valid && (r_key == i_key);

    // on a hit only cells up to the matching one move; on a miss all move
    assign o_match_from = match | i_match_after;
    assign shift_en     = i_ctl.load && (!i_ctl.hit || o_match_from);

    assign o_rank_acc = i_rank_acc | (match ? RK_W'(IDX) : '0);
    assign o_last_acc = i_last_acc | (is_last ? r_key : '0);
    assign o_key      = r_key;

    always_ff @(posedge i_clk) begin
        if (shift_en) begin
            r_key <= i_prev_key;
        end
    end

endmodule

// ----- rtl/lru_tag_cache_core.sv -----
`timescale 1ns / 1ps
// lru_tag_cache_core: fully associative tag store kept in recency order
//
// input channel (i_valid / o_ready): one transfer carries an operation and
// a key. an access looks the key up in all cells at once; on a hit the key
// moves to the front and its earlier rank is reported, on a miss the oldest
// keys are dropped until one more fits within capacity and the key is put
// at the front. a clear empties the store and reports how many were held.
// output channel (o_valid / i_ready): one result transfer per input.
// o_valid rises in the cycle after the input transfer. one item per cycle is
// sustained while the receiver accepts: the lookup, the cell row shift and
// the count update all finish in the cycle the item is taken, so the result
// register is the only stage. while the receiver stalls the result is held
// and o_ready drops, so at most one result waits.
// reset clears the entry count and the output valid and sets capacity to
// 16; the key cells are not cleared, cells beyond the count are never used.
// capacity is written over the APB port at byte address 0 (0 acts as 1,
// values above DEPTH act as DEPTH); write it only while the block is idle.
module lru_tag_cache_core #(
    parameter int DEPTH     = lrc_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = lrc_pkg::KEY_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_operation,
    input  logic [lrc_pkg::KEY_W-1:0]  i_key,
    // output channel
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_hit,
    output logic [lrc_pkg::RANK_W-1:0] o_prior_rank,
    output logic [lrc_pkg::CNT_OUT_W-1:0] o_dropped_count,
    output logic [lrc_pkg::KEY_W-1:0]  o_dropped_key,
    output logic [lrc_pkg::CNT_OUT_W-1:0] o_occupancy,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lrc_pkg::APB_AW-1:0] paddr,
    input  logic [lrc_pkg::APB_DW-1:0] pwdata,
    output logic [lrc_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import lrc_pkg::*;

    // stored key width: keys never carry bits above 32
    localparam int SW    = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int RK_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int RKX   = (RK_W > RANK_W) ? RK_W : RANK_W;

    // registers
    logic [CAP_W-1:0] r_capacity;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid;
    logic             r_hit;
    logic [RANK_W-1:0]    r_rank;
    logic [CNT_OUT_W-1:0] r_dcount;
    logic [KEY_W-1:0]     r_dkey;
    logic [CNT_OUT_W-1:0] r_occ;

    // item datapath
    logic             take;
    t_op              op;
    logic [SW-1:0]    key_in;
    t_cell_ctl        ctl;
    logic             hit;
    logic [RK_W-1:0]  rank;
    logic [SW-1:0]    last_key;
    logic [EW-1:0]    cap_ext, cap_eff, count_ext, dcount_e, occ_e;
    logic [KEY_W-1:0] dkey;
    logic [RKX-1:0]   rank_x;

    // cell chain wiring: index DEPTH is the tail end of the OR chains
    logic [SW-1:0]   key_chain  [DEPTH+1];
    logic            match_chain[DEPTH+1];
    logic [RK_W-1:0] rank_chain [DEPTH+1];
    logic [SW-1:0]   last_chain [DEPTH+1];

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DW'(r_capacity) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    // ---------------- handshake ----------------
    // a new transfer is taken whenever the result register is free or drains now
    assign o_ready = !r_out_valid || i_ready;
    assign take    = i_valid && o_ready;
    assign op      = t_op'(i_operation);
    assign key_in  = i_key[SW-1:0];

    assign ctl.load = take && (op == OP_ACCESS);
    assign ctl.hit  = hit;

    // ---------------- cell row ----------------
    assign key_chain[0]       = key_in;
    assign match_chain[DEPTH] = 1'b0;
    assign rank_chain[DEPTH]  = '0;
    assign last_chain[DEPTH]  = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        lrc_cell #(
            .IDX   (g),
            .SW    (SW),
            .RK_W  (RK_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_count       (r_count),
            .i_key         (key_in),
            .i_prev_key    (key_chain[g]),
            .i_match_after (match_chain[g+1]),
            .i_rank_acc    (rank_chain[g+1]),
            .i_last_acc    (last_chain[g+1]),
            .o_key         (key_chain[g+1]),
            .o_match_from  (match_chain[g]),
            .o_rank_acc    (rank_chain[g]),
            .o_last_acc    (last_chain[g])
        );
    end

    // keys in valid cells are unique, so at most one cell matches
    assign hit      = match_chain[0];
    assign rank     = rank_chain[0];
    assign last_key = last_chain[0];

    // ---------------- count and result ----------------
    assign cap_ext   = EW'(r_capacity);
    assign count_ext = EW'(r_count);

    always_comb begin
        // zero capacity acts as one, anything above the row length as the row length
        if (cap_ext == '0) begin
            cap_eff = EW'(1);
        end else if (cap_ext > EW'(DEPTH)) begin
            cap_eff = EW'(DEPTH);
        end else begin
            cap_eff = cap_ext;
        end
    end

    always_comb begin
        dcount_e = '0;
        occ_e    = count_ext;
        dkey     = '0;
        if (op == OP_CLEAR) begin
            dcount_e = count_ext;
            occ_e    = '0;
        end else if (!hit) begin
            if (count_ext >= cap_eff) begin
                // evict the oldest keys, report the oldest one
                dcount_e = count_ext - cap_eff + EW'(1);
                occ_e    = cap_eff;
                dkey     = KEY_W'(last_key);
            end else begin
                occ_e    = count_ext + EW'(1);
            end
        end
    end

    assign n_count = occ_e[CNT_W-1:0];
    assign rank_x  = RKX'(rank);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_count <= n_count;
            end
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_hit    <= (op == OP_ACCESS) && hit;
            r_rank   <= ((op == OP_ACCESS) && hit) ? rank_x[RANK_W-1:0] : '0;
            r_dcount <= dcount_e[CNT_OUT_W-1:0];
            r_dkey   <= dkey;
            r_occ    <= occ_e[CNT_OUT_W-1:0];
        end
    end

    assign o_valid         = r_out_valid;
    assign o_hit           = r_hit;
    assign o_prior_rank    = r_rank;
    assign o_dropped_count = r_dcount;
    assign o_dropped_key   = r_dkey;
    assign o_occupancy     = r_occ;

endmodule

// ----- verif/tb_lru_tag_cache_core.sv -----
`timescale 1ns / 1ps
module tb_lru_tag_cache_core;

    import lrc_pkg::*;

    // cycles before the run is declared hung
    localparam int CYCLE_LIMIT = 400000;
    localparam int POOL_SIZE   = 24;

    // one expected result transfer
    typedef struct packed {
        logic                 hit;
        logic [RANK_W-1:0]    prior_rank;
        logic [CNT_OUT_W-1:0] dropped_count;
        logic [KEY_W-1:0]     dropped_key;
        logic [CNT_OUT_W-1:0] occupancy;
    } lookup_result_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic                 i_operation;
    logic [KEY_W-1:0]     i_key;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic                 o_hit;
    logic [RANK_W-1:0]    o_prior_rank;
    logic [CNT_OUT_W-1:0] o_dropped_count;
    logic [KEY_W-1:0]     o_dropped_key;
    logic [CNT_OUT_W-1:0] o_occupancy;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // shadow copy of the tag store, most recent key in slot 0
    logic [KEY_W-1:0]     shadow_keys [DEPTH_DEF];
    int                   shadow_count;
    int                   shadow_capacity;

    lookup_result_t       expected_lookups [$];
    int                   mismatch_count;
    int                   cycle_count;

    // idling control: percent chance of a gap or stall burst, and a master enable
    bit                   idle_enabled;
    int                   gap_pct;
    int                   stall_pct;

    lru_tag_cache_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_operation     (i_operation),
        .i_key           (i_key),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_hit           (o_hit),
        .o_prior_rank    (o_prior_rank),
        .o_dropped_count (o_dropped_count),
        .o_dropped_key   (o_dropped_key),
        .o_occupancy     (o_occupancy),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor: applies one operation to the shadow store
    // ------------------------------------------------------------------

    function automatic lookup_result_t predict_lookup(input t_op op,
                                                      input logic [KEY_W-1:0] key);
        lookup_result_t res;
        int             pos;
        int             room;
        int             i;
        res = '0;
        pos = -1;
        if (op == OP_CLEAR) begin
            // clear reports how many keys were held, no evicted key
            res.dropped_count = CNT_OUT_W'(shadow_count);
            shadow_count = 0;
        end else begin
            for (i = 0; i < shadow_count; i++) begin
                if (pos < 0 && shadow_keys[i] == key)
                    pos = i;
            end
            if (pos >= 0) begin
                // hit: move to front, nothing dropped even if over capacity
                res.hit        = 1'b1;
                res.prior_rank = RANK_W'(pos);
                for (i = pos; i > 0; i--)
                    shadow_keys[i] = shadow_keys[i - 1];
                shadow_keys[0] = key;
            end else begin
                // capacity 0 acts as 1, above the store depth acts as the depth
                room = (shadow_capacity == 0) ? 1 :
                       (shadow_capacity > DEPTH_DEF) ? DEPTH_DEF : shadow_capacity;
                if (shadow_count + 1 > room) begin
                    // report the oldest of the dropped keys
                    res.dropped_key   = shadow_keys[shadow_count - 1];
                    res.dropped_count = CNT_OUT_W'(shadow_count + 1 - room);
                    shadow_count      = room - 1;
                end
                for (i = shadow_count; i > 0; i--)
                    shadow_keys[i] = shadow_keys[i - 1];
                shadow_keys[0] = key;
                shadow_count++;
            end
        end
        res.occupancy = CNT_OUT_W'(shadow_count);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // shared stimulus tasks, all entered right after a rising edge
    // ------------------------------------------------------------------

    // one input transfer, with an optional gap burst before it
    task automatic send_item(input t_op op, input logic [KEY_W-1:0] key);
        if (idle_enabled && $urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(7, 1)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_key       <= key;
        do @(posedge i_clk); while (!o_ready);
        expected_lookups.push_back(predict_lookup(op, key));
    endtask

    // stop sending and wait until every expected result transfer has come
    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (expected_lookups.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // apb write of the capacity register, only once the block is idle
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_for_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CAPACITY, 2'b00};
        // upper data bits are junk, only the low field counts
        pwdata  <= {(APB_DW - CAP_W)'($urandom()), cap};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_capacity = int'(cap);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // key extremes, fill to full, eviction, deepest hit, clear on empty
    // then capacity lowered below occupancy, capacity 1 and capacity 0
    task automatic test_directed();
        logic [KEY_W-1:0] fill [1:16];
        int               i;
        for (i = 1; i <= 16; i++)
            fill[i] = {4'h5, 24'($urandom()), 4'(i - 1)};
        send_item(OP_CLEAR, '1);                // clear of an empty store
        send_item(OP_ACCESS, '0);
        send_item(OP_ACCESS, '1);
        send_item(OP_ACCESS, '0);               // hit at rank 1, all-ones now oldest
        for (i = 1; i <= 14; i++)
            send_item(OP_ACCESS, fill[i]);      // store full at the reset capacity
        send_item(OP_ACCESS, fill[15]);         // evicts the all-ones key
        send_item(OP_ACCESS, '0);               // hit at the deepest rank
        write_capacity(CAP_W'(1));              // lowered far below occupancy
        send_item(OP_ACCESS, fill[1]);          // hit only reorders
        send_item(OP_ACCESS, fill[16]);         // miss drops all sixteen
        send_item(OP_ACCESS, fill[16]);
        send_item(OP_ACCESS, fill[3]);
        write_capacity(CAP_W'(0));              // zero behaves as one
        send_item(OP_ACCESS, fill[4]);
        send_item(OP_CLEAR, $urandom());
    endtask

    // random phases over a spread of capacities, mostly keys from a small pool
    task automatic test_random_phases();
        logic [KEY_W-1:0] key_pool [POOL_SIZE];
        logic [CAP_W-1:0] cap_list [8];
        int               pool_n;
        int               roll;
        int               p;
        int               n;
        cap_list = '{CAP_W'(31), CAP_W'(1), CAP_W'(0), CAP_W'(17), CAP_W'(16),
                     CAP_W'($urandom_range(15, 2)), CAP_W'($urandom()), CAP_W'(8)};
        for (p = 0; p < 8; p++) begin
            write_capacity(cap_list[p]);
            for (n = 0; n < POOL_SIZE; n++)
                key_pool[n] = $urandom();
            pool_n    = $urandom_range(POOL_SIZE, 2);
            gap_pct   = ($urandom_range(2) == 0) ? 0 : $urandom_range(40, 10);
            stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(40, 10);
            for (n = 0; n < 100; n++) begin
                // in odd phases the sender holds off mid-phase until everything is back
                if (n == 50 && p[0])
                    wait_for_results();
                roll = $urandom_range(99);
                if (roll < 4)
                    send_item(OP_CLEAR, $urandom());
                else if (roll < 24)
                    send_item(OP_ACCESS, $urandom());
                else
                    send_item(OP_ACCESS, key_pool[$urandom_range(pool_n - 1)]);
            end
        end
    endtask

    // last stretch at full rate on both sides
    task automatic test_full_rate();
        logic [KEY_W-1:0] key_pool [POOL_SIZE];
        int               n;
        write_capacity(CAP_W'(16));
        idle_enabled = 1'b0;
        for (n = 0; n < POOL_SIZE; n++)
            key_pool[n] = $urandom();
        for (n = 0; n < 100; n++) begin
            if ($urandom_range(49) == 0)
                send_item(OP_CLEAR, $urandom());
            else
                send_item(OP_ACCESS, key_pool[$urandom_range(POOL_SIZE - 1)]);
        end
    endtask

    // ------------------------------------------------------------------
    // result side: random stall bursts and checking
    // ------------------------------------------------------------------

    // receiver stalls come in bursts of random length
    always @(posedge i_clk) begin : receiver_stalls
        int stall_left;
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (idle_enabled && $urandom_range(99) < stall_pct) begin
            stall_left = $urandom_range(7, 1) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic check_field(input string field, input logic [KEY_W-1:0] want,
                               input logic [KEY_W-1:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0d: %s mismatch, expected %h, got %h",
                         cycle_count, field, want, got);
        end
    endtask

    // each result transfer is matched against the oldest prediction
    always @(posedge i_clk) begin : result_checker
        lookup_result_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_lookups.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0d: result transfer with nothing expected", cycle_count);
            end else begin
                want = expected_lookups.pop_front();
                check_field("hit", KEY_W'(want.hit), KEY_W'(o_hit));
                check_field("prior_rank", KEY_W'(want.prior_rank), KEY_W'(o_prior_rank));
                check_field("dropped_count", KEY_W'(want.dropped_count),
                            KEY_W'(o_dropped_count));
                check_field("dropped_key", want.dropped_key, o_dropped_key);
                check_field("occupancy", KEY_W'(want.occupancy), KEY_W'(o_occupancy));
            end
        end
    end

    // hang guard
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_operation     <= OP_ACCESS;
        i_key           <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        mismatch_count  = 0;
        shadow_count    = 0;
        shadow_capacity = int'(CAP_RESET);
        idle_enabled    = 1'b1;
        gap_pct         = 25;
        stall_pct       = 25;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_phases();
        test_full_rate();

        // let the last results drain, then wait for stragglers
        wait_for_results();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0 && expected_lookups.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
